/* rtl/core/srbs_pkg.sv */
// Shared types, constants and the segment-size helper function of the selective-repeat byte sender.
package srbs_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_SEGMENTS = 64;
  localparam int BUF_AW = $clog2(BUFFER_BYTES);
  localparam int POS_W = BUF_AW + 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [10:0] SEG_RESET = 11'd200;
  localparam logic [15:0] MAXWIN_RESET = 16'd4096;
  localparam logic [31:0] TIMEOUT_RESET = 32'd150000;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_TMO = 2'd2;
  localparam logic [1:0] REQ_SCAN = 2'd3;

  localparam logic [1:0] KIND_SEG = 2'd0;
  localparam logic [1:0] KIND_DRAINED = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [1:0] CFG_SEG = 2'd0;
  localparam logic [1:0] CFG_MAXWIN = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0] req;
    logic [31:0] now;
    logic [31:0] aseq;
    logic [15:0] alen;
    logic [POS_W-1:0] fill;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic fin;
    logic has;
    logic [1:0] kind;
    logic [31:0] seq;
    logic [10:0] len;
    logic [15:0] win;
  } res_t;

  function automatic logic [10:0] seg_size(input logic [10:0] s);
    logic [10:0] v;
    if (s == 11'd0) v = 11'd1;
    else if (s > 11'd1024) v = 11'd1024;
    else v = s;
    return v;
  endfunction

endpackage

/* rtl/core/srbs_front.sv */
// Front part: accepts requests, saturates the fill length and queues them.
module srbs_front (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_req_type,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_ack_seq,
  input  logic [15:0] in_ack_len,
  input  logic [12:0] in_fill_len,
  output logic q_valid,
  output srbs_pkg::cmd_t q_head,
  input  logic q_pop
);

  srbs_pkg::cmd_t ent_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;
  srbs_pkg::cmd_t in_cmd;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = ent_r[rp_r];

  always_comb begin
    in_cmd.req = in_req_type;
    in_cmd.now = in_now_us;
    in_cmd.aseq = in_ack_seq;
    in_cmd.alen = in_ack_len;
    if (32'(in_fill_len) > 32'(srbs_pkg::BUFFER_BYTES)) begin
      in_cmd.fill = srbs_pkg::POS_W'(srbs_pkg::BUFFER_BYTES);
    end else begin
      in_cmd.fill = srbs_pkg::POS_W'(in_fill_len);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/core/srbs_back.sv */
// Back part: sequencer over the per-byte memories that carries out each request.
module srbs_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  srbs_pkg::cmd_t q_head,
  output logic q_pop,
  input  logic [10:0] seg_cfg,
  input  logic [15:0] maxwin_cfg,
  input  logic [31:0] timeout_cfg,
  output srbs_pkg::res_t res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_CLR = 4'd2;
  localparam logic [3:0] S_ACK0 = 4'd3;
  localparam logic [3:0] S_ACK1 = 4'd4;
  localparam logic [3:0] S_AWR = 4'd5;
  localparam logic [3:0] S_SBRD = 4'd6;
  localparam logic [3:0] S_SBCHK = 4'd7;
  localparam logic [3:0] S_SCDEC = 4'd8;
  localparam logic [3:0] S_LPRD = 4'd9;
  localparam logic [3:0] S_LPEV = 4'd10;
  localparam logic [3:0] S_MK = 4'd11;
  localparam logic [3:0] S_LPEND = 4'd12;
  localparam logic [3:0] S_SCFIN = 4'd13;
  localparam logic [3:0] S_FIN = 4'd14;

  localparam int PW = srbs_pkg::POS_W;

  logic mem_acked [srbs_pkg::BUFFER_BYTES];
  logic mem_sent [srbs_pkg::BUFFER_BYTES];
  logic [31:0] mem_time [srbs_pkg::BUFFER_BYTES];
  logic acked_rd_r, sent_rd_r;
  logic [31:0] time_rd_r;

  logic [3:0] state_r, state_nxt;
  srbs_pkg::cmd_t cmd_r, cmd_nxt;
  logic [15:0] window_r, window_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [31:0] bseq_r, bseq_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic [PW-1:0] r_r, r_nxt;
  logic [PW-1:0] l_r, l_nxt;
  logic active_r, active_nxt;
  logic [srbs_pkg::CNT_W-1:0] n_r, n_nxt;
  logic ret_fin_r, ret_fin_nxt;
  logic [1:0] fkind_r, fkind_nxt;
  logic [31:0] diff_r, diff_nxt;

  logic [10:0] seg;
  logic [srbs_pkg::BUF_AW-1:0] rd_addr, wr_addr;
  logic wr_acked, wr_sent, wr_time, acked_val, sent_val;
  logic elig, loop_ok;
  logic signed [33:0] e_sum;
  logic [PW-1:0] sc, ec;
  logic [16:0] w_inc;
  logic [15:0] w_half;

  assign seg = srbs_pkg::seg_size(seg_cfg);
  assign rd_addr = (state_r == S_SBRD) ? base_r[srbs_pkg::BUF_AW-1:0]
                                       : r_r[srbs_pkg::BUF_AW-1:0];
  assign wr_addr = idx_r[srbs_pkg::BUF_AW-1:0];
  assign elig = !acked_rd_r && (!sent_rd_r || ((cmd_r.now - time_rd_r) >= timeout_cfg));
  assign loop_ok = (32'(r_r - base_r) < 32'(window_r)) && (r_r < len_r)
                   && (32'(n_r) < 32'(srbs_pkg::MAX_SEGMENTS));
  assign e_sum = {{2{diff_r[31]}}, diff_r} + {18'b0, cmd_r.alen};
  assign w_inc = {1'b0, window_r} + {6'b0, seg};
  assign w_half = window_r >> 1;

  always_comb begin
    if (diff_r[31]) sc = '0;
    else if (diff_r > 32'(len_r)) sc = len_r;
    else sc = PW'(diff_r);
    if (e_sum[33]) ec = '0;
    else if (e_sum[32:0] > 33'(len_r)) ec = len_r;
    else ec = PW'(e_sum[32:0]);
  end

  always_ff @(posedge clk) begin
    acked_rd_r <= mem_acked[rd_addr];
    sent_rd_r <= mem_sent[rd_addr];
    time_rd_r <= mem_time[rd_addr];
    if (wr_acked) mem_acked[wr_addr] <= acked_val;
    if (wr_sent) mem_sent[wr_addr] <= sent_val;
    if (wr_time) mem_time[wr_addr] <= cmd_r.now;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    window_nxt = window_r;
    base_nxt = base_r;
    len_nxt = len_r;
    bseq_nxt = bseq_r;
    idx_nxt = idx_r;
    end_nxt = end_r;
    r_nxt = r_r;
    l_nxt = l_r;
    active_nxt = active_r;
    n_nxt = n_r;
    ret_fin_nxt = ret_fin_r;
    fkind_nxt = fkind_r;
    diff_nxt = diff_r;
    q_pop = 1'b0;
    wr_acked = 1'b0;
    wr_sent = 1'b0;
    wr_time = 1'b0;
    acked_val = 1'b0;
    sent_val = 1'b0;
    res = '0;
    res.win = window_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_head;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_r.req)
          srbs_pkg::REQ_LOAD: begin
            bseq_nxt = bseq_r + 32'(len_r);
            len_nxt = cmd_r.fill;
            base_nxt = '0;
            idx_nxt = '0;
            state_nxt = S_CLR;
          end
          srbs_pkg::REQ_ACK: begin
            diff_nxt = cmd_r.aseq - bseq_r;
            state_nxt = S_ACK0;
          end
          srbs_pkg::REQ_TMO: begin
            window_nxt = (w_half < 16'(seg)) ? 16'(seg) : w_half;
            fkind_nxt = srbs_pkg::KIND_NOTHING;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_SBRD;
        endcase
      end
      S_CLR: begin
        if (idx_r < len_r) begin
          wr_acked = 1'b1;
          wr_sent = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          fkind_nxt = (len_r == '0) ? srbs_pkg::KIND_DONE : srbs_pkg::KIND_NOTHING;
          state_nxt = S_FIN;
        end
      end
      S_ACK0: begin
        idx_nxt = sc;
        end_nxt = ec;
        state_nxt = S_ACK1;
      end
      S_ACK1: begin
        if (end_r > idx_r) begin
          window_nxt = (w_inc > 17'(maxwin_cfg)) ? maxwin_cfg : w_inc[15:0];
        end
        state_nxt = S_AWR;
      end
      S_AWR: begin
        if (idx_r < end_r) begin
          wr_acked = 1'b1;
          acked_val = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          fkind_nxt = srbs_pkg::KIND_NOTHING;
          state_nxt = S_FIN;
        end
      end
      S_SBRD: begin
        state_nxt = (base_r < len_r) ? S_SBCHK : S_SCDEC;
      end
      S_SBCHK: begin
        if (acked_rd_r) begin
          base_nxt = base_r + 1'b1;
          state_nxt = S_SBRD;
        end else begin
          state_nxt = S_SCDEC;
        end
      end
      S_SCDEC: begin
        if (len_r == '0) begin
          fkind_nxt = srbs_pkg::KIND_DONE;
          state_nxt = S_FIN;
        end else if (base_r == len_r) begin
          fkind_nxt = srbs_pkg::KIND_DRAINED;
          state_nxt = S_FIN;
        end else begin
          r_nxt = base_r;
          active_nxt = 1'b0;
          n_nxt = '0;
          state_nxt = S_LPRD;
        end
      end
      S_LPRD: begin
        state_nxt = loop_ok ? S_LPEV : S_LPEND;
      end
      S_LPEV: begin
        r_nxt = r_r + 1'b1;
        state_nxt = S_LPRD;
        if (active_r && (!elig || (r_r - l_r) == PW'(seg))) begin
          res.emit = 1'b1;
          res.kind = srbs_pkg::KIND_SEG;
          res.seq = bseq_r + 32'(l_r);
          res.len = 11'(r_r - l_r);
          n_nxt = n_r + 1'b1;
          idx_nxt = l_r;
          end_nxt = r_r;
          ret_fin_nxt = 1'b0;
          state_nxt = S_MK;
          if (elig) l_nxt = r_r;
          else active_nxt = 1'b0;
        end else if (elig && !active_r) begin
          active_nxt = 1'b1;
          l_nxt = r_r;
        end
      end
      S_MK: begin
        if (idx_r < end_r) begin
          wr_sent = 1'b1;
          wr_time = 1'b1;
          sent_val = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = ret_fin_r ? S_SCFIN : S_LPRD;
        end
      end
      S_LPEND: begin
        if (active_r && (32'(n_r) < 32'(srbs_pkg::MAX_SEGMENTS))) begin
          res.emit = 1'b1;
          res.kind = srbs_pkg::KIND_SEG;
          res.seq = bseq_r + 32'(l_r);
          res.len = 11'(r_r - l_r);
          n_nxt = n_r + 1'b1;
          idx_nxt = l_r;
          end_nxt = r_r;
          ret_fin_nxt = 1'b1;
          state_nxt = S_MK;
        end else begin
          state_nxt = S_SCFIN;
        end
      end
      S_SCFIN: begin
        res.fin = 1'b1;
        res.has = (n_r == '0);
        res.kind = srbs_pkg::KIND_NOTHING;
        state_nxt = S_IDLE;
      end
      S_FIN: begin
        res.fin = 1'b1;
        res.has = 1'b1;
        res.kind = fkind_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      window_r <= 16'(srbs_pkg::SEG_RESET);
      base_r <= '0;
      len_r <= '0;
      bseq_r <= '0;
      active_r <= 1'b0;
      n_r <= '0;
      ret_fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      window_r <= window_nxt;
      base_r <= base_nxt;
      len_r <= len_nxt;
      bseq_r <= bseq_nxt;
      active_r <= active_nxt;
      n_r <= n_nxt;
      ret_fin_r <= ret_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    end_r <= end_nxt;
    r_r <= r_nxt;
    l_r <= l_nxt;
    fkind_r <= fkind_nxt;
    diff_r <= diff_nxt;
  end

  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.emit && res.fin)) else $error("emit and finish in one cycle");
  a_seg_len: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |-> (res.len != 11'd0 && res.len <= seg)) else $error("bad segment length");
  a_seg_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_r) <= 32'(srbs_pkg::MAX_SEGMENTS)) else $error("segment count overrun");
  a_emit_mark: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |=> (state_r == S_MK)) else $error("segment not marked as sent");

endmodule

/* rtl/core/srbs_out.sv */
// Result stage: holds one segment back so that the final result carries last.
module srbs_out (
  input  logic clk,
  input  logic rst_n,
  input  srbs_pkg::res_t res,
  output logic out_valid,
  output logic [1:0] out_kind,
  output logic [31:0] out_seg_seq,
  output logic [10:0] out_seg_len,
  output logic [15:0] out_window_now,
  output logic out_last
);

  logic pv_r;
  srbs_pkg::res_t pend_r;
  logic ov_r, last_r;
  srbs_pkg::res_t o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= (res.emit && pv_r) || (res.fin && (res.has || pv_r));
      if (res.emit) pv_r <= 1'b1;
      else if (res.fin) pv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) pend_r <= res;
    if (res.fin && res.has) begin
      o_r <= res;
      last_r <= 1'b1;
    end else begin
      o_r <= pend_r;
      last_r <= res.fin;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = o_r.kind;
  assign out_seg_seq = o_r.seq;
  assign out_seg_len = o_r.len;
  assign out_window_now = o_r.win;
  assign out_last = last_r;

endmodule

/* rtl/core/selective_repeat_byte_sender.sv */
// Top level of the selective-repeat byte sender: configuration registers and part wiring.
// A load clears the loaded bytes one at a time; an ack marks its clipped range byte by byte.
// A scan walks the acked bytes at the base, then the window bytes, and marks the bytes
// of each emitted segment as sent.
// Requests run one at a time; a two-entry queue holds waiting ones and raises busy when full.
// Reset clears control state; window returns to 200, registers to their defaults.
// Results are strobed for one cycle each; the receiver cannot stall.
module selective_repeat_byte_sender (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_req_type,
  input  logic [31:0] in_now_us,
  input  logic [31:0] in_ack_seq,
  input  logic [15:0] in_ack_len,
  input  logic [12:0] in_fill_len,
  output logic out_valid,
  output logic [1:0] out_kind,
  output logic [31:0] out_seg_seq,
  output logic [10:0] out_seg_len,
  output logic [15:0] out_window_now,
  output logic out_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic [10:0] seg_r;
  logic [15:0] maxwin_r;
  logic [31:0] timeout_r;
  logic q_valid, q_pop;
  srbs_pkg::cmd_t q_head;
  srbs_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= srbs_pkg::SEG_RESET;
      maxwin_r <= srbs_pkg::MAXWIN_RESET;
      timeout_r <= srbs_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srbs_pkg::CFG_SEG: seg_r <= cfg_data[10:0];
        srbs_pkg::CFG_MAXWIN: maxwin_r <= cfg_data[15:0];
        srbs_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  srbs_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_now_us(in_now_us), .in_ack_seq(in_ack_seq),
    .in_ack_len(in_ack_len), .in_fill_len(in_fill_len),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  srbs_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .seg_cfg(seg_r), .maxwin_cfg(maxwin_r), .timeout_cfg(timeout_r), .res(res)
  );

  srbs_out u_out (
    .clk(clk), .rst_n(rst_n), .res(res), .out_valid(out_valid), .out_kind(out_kind),
    .out_seg_seq(out_seg_seq), .out_seg_len(out_seg_len),
    .out_window_now(out_window_now), .out_last(out_last)
  );

endmodule

/* verif/selective_repeat_byte_sender_tb.sv */
// Self-checking testbench for the selective-repeat byte sender: random and directed commands.
`timescale 1ns / 100ps

module selective_repeat_byte_sender_tb;

  typedef struct {
    logic [1:0] req;
    logic [31:0] now;
    logic [31:0] aseq;
    logic [15:0] alen;
    logic [12:0] fill;
  } cmd_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [31:0] seq;
    logic [10:0] len;
    logic [15:0] win;
    logic last;
  } seg_result_t;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = srbs_pkg::REQ_LOAD;
  logic [31:0] in_now_us = '0;
  logic [31:0] in_ack_seq = '0;
  logic [15:0] in_ack_len = '0;
  logic [12:0] in_fill_len = '0;
  logic out_valid;
  logic [1:0] out_kind;
  logic [31:0] out_seg_seq;
  logic [10:0] out_seg_len;
  logic [15:0] out_window_now;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = srbs_pkg::CFG_SEG;
  logic [31:0] cfg_data = '0;

  cmd_item_t pending_cmds[$];
  seg_result_t expected_results[$];
  int fail_count = 0;
  int idle_left = 0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  logic [10:0] seg_reg;
  logic [15:0] maxwin_reg;
  logic [31:0] timeout_reg;
  bit acked_mark[srbs_pkg::BUFFER_BYTES];
  bit sent_mark[srbs_pkg::BUFFER_BYTES];
  logic [31:0] sent_stamp[srbs_pkg::BUFFER_BYTES];
  logic [31:0] window_cur;
  int unsigned base_pos;
  int unsigned buf_len;
  logic [31:0] buf_seq;
  logic [31:0] last_seg_seq;
  int unsigned last_seg_len;
  logic [31:0] clock_us;

  selective_repeat_byte_sender dut (.*);

  always #4 clk = ~clk;

  task automatic add_result(input logic [1:0] kind, input logic [31:0] seq,
                            input int unsigned len);
    seg_result_t r;
    r.kind = kind;
    r.seq = seq;
    r.len = len[10:0];
    r.win = window_cur[15:0];
    r.last = 1'b0;
    expected_results = {expected_results, r};
    if (kind == srbs_pkg::KIND_SEG) begin
      last_seg_seq = seq;
      last_seg_len = len;
    end
  endtask

  task automatic emit_segment(input int unsigned l, input int unsigned r,
                              input logic [31:0] now);
    add_result(srbs_pkg::KIND_SEG, buf_seq + l, r - l);
    for (int unsigned i = l; i < r; i++) begin
      sent_mark[i] = 1'b1;
      sent_stamp[i] = now;
    end
  endtask

  task automatic predict_results(input cmd_item_t c);
    int unsigned seg;
    int unsigned fill;
    int unsigned r;
    int unsigned l;
    int unsigned n;
    int unsigned w;
    bit active;
    bit ok;
    longint a_start;
    longint a_end;
    logic [31:0] diff;
    seg = (seg_reg == 0) ? 1 : (seg_reg > 1024) ? 1024 : seg_reg;
    n = 0;
    case (c.req)
      srbs_pkg::REQ_LOAD: begin
        fill = (c.fill > srbs_pkg::BUFFER_BYTES) ? srbs_pkg::BUFFER_BYTES : c.fill;
        buf_seq = buf_seq + buf_len;
        buf_len = fill;
        for (int i = 0; i < srbs_pkg::BUFFER_BYTES; i++) begin
          acked_mark[i] = 1'b0;
          sent_mark[i] = 1'b0;
        end
        base_pos = 0;
        add_result(fill == 0 ? srbs_pkg::KIND_DONE : srbs_pkg::KIND_NOTHING, '0, 0);
      end
      srbs_pkg::REQ_ACK: begin
        diff = c.aseq - buf_seq;
        a_start = longint'($signed(diff));
        a_end = a_start + longint'(c.alen);
        if (a_start < 0) a_start = 0;
        if (a_end > longint'(buf_len)) a_end = longint'(buf_len);
        if (a_end > a_start) begin
          for (longint i = a_start; i < a_end; i++) acked_mark[i] = 1'b1;
          w = window_cur + seg;
          if (w > maxwin_reg) w = maxwin_reg;
          window_cur = w;
        end
        add_result(srbs_pkg::KIND_NOTHING, '0, 0);
      end
      srbs_pkg::REQ_TMO: begin
        w = window_cur / 2;
        if (w < seg) w = seg;
        window_cur = w;
        add_result(srbs_pkg::KIND_NOTHING, '0, 0);
      end
      default: begin
        while (base_pos < buf_len && acked_mark[base_pos]) base_pos++;
        if (buf_len == 0) begin
          add_result(srbs_pkg::KIND_DONE, '0, 0);
        end else if (base_pos == buf_len) begin
          add_result(srbs_pkg::KIND_DRAINED, '0, 0);
        end else begin
          r = base_pos;
          l = 0;
          active = 1'b0;
          while (r - base_pos < window_cur && r < buf_len && n < srbs_pkg::MAX_SEGMENTS) begin
            ok = !acked_mark[r] && (!sent_mark[r] || (c.now - sent_stamp[r]) >= timeout_reg);
            if (ok) begin
              if (active && r - l == seg) begin
                emit_segment(l, r, c.now);
                n++;
                l = r;
              end else if (!active) begin
                active = 1'b1;
                l = r;
              end
            end else if (active) begin
              emit_segment(l, r, c.now);
              n++;
              active = 1'b0;
            end
            r++;
          end
          if (active && n < srbs_pkg::MAX_SEGMENTS) begin
            emit_segment(l, r, c.now);
            n++;
          end
          if (n == 0) add_result(srbs_pkg::KIND_NOTHING, '0, 0);
        end
      end
    endcase
    expected_results[$].last = 1'b1;
  endtask

  // Driver: one command per transfer, random idle bursts between transfers.
  always @(posedge clk) begin
    cmd_item_t c;
    bit next_start;
    if (rst_n) begin
      next_start = start;
      if (start && !busy) begin
        predict_results(pending_cmds.pop_front());
        next_start = 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 14);
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds[0];
          in_req_type <= c.req;
          in_now_us <= c.now;
          in_ack_seq <= c.aseq;
          in_ack_len <= c.alen;
          in_fill_len <= c.fill;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    seg_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d seq=%0d len=%0d", out_kind, out_seg_seq,
               out_seg_len);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, out_kind);
          fail_count++;
        end
        if (out_seg_seq !== e.seq) begin
          $error("seg_seq: expected %0d, actual %0d", e.seq, out_seg_seq);
          fail_count++;
        end
        if (out_seg_len !== e.len) begin
          $error("seg_len: expected %0d, actual %0d", e.len, out_seg_len);
          fail_count++;
        end
        if (out_window_now !== e.win) begin
          $error("window_now: expected %0d, actual %0d", e.win, out_window_now);
          fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      srbs_pkg::CFG_SEG: seg_reg = val[10:0];
      srbs_pkg::CFG_MAXWIN: maxwin_reg = val[15:0];
      srbs_pkg::CFG_TIMEOUT: timeout_reg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (30) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic add_cmd(input logic [1:0] req, input logic [31:0] now,
                         input logic [31:0] aseq, input logic [15:0] alen,
                         input logic [12:0] fill);
    cmd_item_t c;
    c.req = req;
    c.now = now;
    c.aseq = aseq;
    c.alen = alen;
    c.fill = fill;
    pending_cmds = {pending_cmds, c};
  endtask

  // Mostly load/scan/ack flows on small buffers, with some noise and odd values.
  task automatic add_random(input int count);
    int pick;
    logic [31:0] seq;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(0, 200000);
      if (pick < 10) begin
        add_cmd(srbs_pkg::REQ_LOAD, $urandom, $urandom, 16'($urandom),
                ($urandom_range(0, 15) == 0) ? 13'($urandom) : 13'($urandom_range(0, 400)));
      end else if (pick < 45) begin
        add_cmd(srbs_pkg::REQ_SCAN, ($urandom_range(0, 9) == 0) ? $urandom : clock_us,
                $urandom, 16'($urandom), 13'($urandom));
      end else if (pick < 88) begin
        wait (pending_cmds.size() == 0);
        if ($urandom_range(0, 2) != 0)
          add_cmd(srbs_pkg::REQ_ACK, $urandom, last_seg_seq, 16'(last_seg_len),
                  13'($urandom));
        else begin
          seq = buf_seq + $urandom_range(0, buf_len + 60) - 30;
          if ($urandom_range(0, 9) == 0) seq = $urandom;
          add_cmd(srbs_pkg::REQ_ACK, $urandom, seq,
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)),
                  13'($urandom));
        end
      end else begin
        add_cmd(srbs_pkg::REQ_TMO, $urandom, $urandom, 16'($urandom), 13'($urandom));
      end
    end
  endtask

  initial begin
    seg_reg = srbs_pkg::SEG_RESET;
    maxwin_reg = srbs_pkg::MAXWIN_RESET;
    timeout_reg = srbs_pkg::TIMEOUT_RESET;
    window_cur = 200;
    base_pos = 0;
    buf_len = 0;
    buf_seq = '0;
    last_seg_seq = '0;
    last_seg_len = 0;
    clock_us = '0;
    for (int i = 0; i < srbs_pkg::BUFFER_BYTES; i++) begin
      acked_mark[i] = 1'b0;
      sent_mark[i] = 1'b0;
      sent_stamp[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_cmd(srbs_pkg::REQ_SCAN, 32'd0, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_LOAD, 32'd0, '0, '0, 13'd10);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd0, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_ACK, '0, 32'd0, 16'd5, '0);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd1, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_TMO, '0, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_TMO, '0, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_ACK, '0, 32'hFFFF_FFF0, 16'd5, '0);
    add_cmd(srbs_pkg::REQ_ACK, '0, 32'h8000_0000, 16'hFFFF, '0);
    add_cmd(srbs_pkg::REQ_ACK, '0, 32'hFFFF_FFFE, 16'd4, '0);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd200000, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_ACK, '0, 32'd0, 16'hFFFF, '0);
    add_cmd(srbs_pkg::REQ_SCAN, 32'hFFFF_FFFF, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_LOAD, '1, '1, '1, 13'h1FFF);
    add_cmd(srbs_pkg::REQ_SCAN, 32'hFFFF_FFFF, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd0, '0, '0, '0);
    add_cmd(srbs_pkg::REQ_LOAD, '0, '0, '0, 13'd4096);
    add_cmd(srbs_pkg::REQ_LOAD, '0, '0, '0, 13'd0);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd0, '0, '0, '0);
    wait_drained();

    write_reg(srbs_pkg::CFG_SEG, 32'd1);
    write_reg(srbs_pkg::CFG_MAXWIN, 32'd65535);
    write_reg(srbs_pkg::CFG_TIMEOUT, 32'd1);
    add_cmd(srbs_pkg::REQ_LOAD, '0, '0, '0, 13'd300);
    add_cmd(srbs_pkg::REQ_SCAN, 32'd5, '0, '0, '0);
    add_random(20);
    wait_drained();

    write_reg(srbs_pkg::CFG_SEG, 32'd1024);
    write_reg(srbs_pkg::CFG_MAXWIN, 32'd1);
    write_reg(srbs_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'hFFFF_FFFF);
    add_random(15);
    wait_drained();

    write_reg(srbs_pkg::CFG_SEG, 32'd0);
    write_reg(srbs_pkg::CFG_MAXWIN, 32'd0);
    add_cmd(srbs_pkg::REQ_ACK, '0, buf_seq, 16'd10, '0);
    add_random(10);
    wait_drained();

    write_reg(srbs_pkg::CFG_SEG, 32'h7FF);
    write_reg(srbs_pkg::CFG_MAXWIN, 32'hFFFF_FFFF);
    write_reg(srbs_pkg::CFG_TIMEOUT, 32'd50000);
    add_random(25);
    wait_drained();

    write_reg(srbs_pkg::CFG_SEG, 32'd37);
    write_reg(srbs_pkg::CFG_MAXWIN, 32'd2000);
    write_reg(srbs_pkg::CFG_TIMEOUT, 32'd150000);
    add_random(25);
    wait (pending_cmds.size() == 0);
    no_idle = 1'b1;
    add_random(25);

    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* selective_repeat_byte_sender.f */
rtl/core/srbs_pkg.sv
rtl/core/srbs_front.sv
rtl/core/srbs_back.sv
rtl/core/srbs_out.sv
rtl/core/selective_repeat_byte_sender.sv
verif/selective_repeat_byte_sender_tb.sv
